FILE: rtl/bcc_pkg.sv
package bcc_pkg;

  // Field widths fixed by the interface definition.
  localparam int BUTTON_W    = 6;
  localparam int KIND_W      = 2;
  localparam int TIME_W      = 32;
  localparam int CFG_W       = 16;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;

  // Default number of buttons served.
  localparam int BUTTON_COUNT_DEF = 4;

  // Register reset values, in milliseconds.
  localparam logic [CFG_W-1:0] DCW_RESET = 16'd300;
  localparam logic [CFG_W-1:0] LPT_RESET = 16'd600;

  // Register indexes (word address bit 2 of the APB port).
  typedef enum logic {
    REG_DCW = 1'b0,
    REG_LPT = 1'b1
  } reg_idx_t;

  // Classification codes.
  typedef enum logic [KIND_W-1:0] {
    KIND_SINGLE = 2'd0,
    KIND_DOUBLE = 2'd1,
    KIND_LONG   = 2'd2
  } kind_t;

  // Configuration handed from the register block to the datapath.
  typedef struct packed {
    logic [CFG_W-1:0] double_click_window;
    logic [CFG_W-1:0] long_press_time;
  } bcc_cfg_t;

endpackage

FILE: rtl/bcc_in_if.sv
interface bcc_in_if;
  logic                          valid;
  logic                          ready;
  logic [bcc_pkg::BUTTON_W-1:0]  button_index;
  logic                          level_pressed;
  logic [bcc_pkg::TIME_W-1:0]    timestamp_ms;

  modport source (output valid, output button_index, output level_pressed,
                  output timestamp_ms, input ready);
  modport sink   (input valid, input button_index, input level_pressed,
                  input timestamp_ms, output ready);
endinterface

FILE: rtl/bcc_out_if.sv
interface bcc_out_if;
  logic                          valid;
  logic                          ready;
  logic [bcc_pkg::BUTTON_W-1:0]  event_button;
  logic [bcc_pkg::KIND_W-1:0]    event_kind;

  modport source (output valid, output event_button, output event_kind, input ready);
  modport sink   (input valid, input event_button, input event_kind, output ready);
endinterface

FILE: rtl/bcc_cfg.sv
module bcc_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [bcc_pkg::APB_ADDR_W-1:0]  cfg_paddr,
  input  logic [bcc_pkg::APB_DATA_W-1:0]  cfg_pwdata,
  output logic [bcc_pkg::APB_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready,
  output bcc_pkg::bcc_cfg_t               cfg_o
);

  logic [bcc_pkg::CFG_W-1:0] dcw_r;
  logic [bcc_pkg::CFG_W-1:0] lpt_r;
  logic                      wr_en;
  bcc_pkg::reg_idx_t         reg_idx;

  // The port never inserts wait states.
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = bcc_pkg::reg_idx_t'(cfg_paddr[2]);

  // Register writes on the access phase of a write transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcw_r <= bcc_pkg::DCW_RESET;
      lpt_r <= bcc_pkg::LPT_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        bcc_pkg::REG_DCW: dcw_r <= cfg_pwdata[bcc_pkg::CFG_W-1:0];
        bcc_pkg::REG_LPT: lpt_r <= cfg_pwdata[bcc_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back of the addressed register.
  always_comb begin
    cfg_prdata = '0;
    unique case (reg_idx)
      bcc_pkg::REG_DCW: cfg_prdata[bcc_pkg::CFG_W-1:0] = dcw_r;
      bcc_pkg::REG_LPT: cfg_prdata[bcc_pkg::CFG_W-1:0] = lpt_r;
      default: cfg_prdata = '0;
    endcase
  end

  assign cfg_o.double_click_window = dcw_r;
  assign cfg_o.long_press_time     = lpt_r;

endmodule

FILE: rtl/button_click_classifier_top.sv
// Button click classifier. Each input transfer carries a button level and a
// millisecond timestamp; a release of a pressed button yields one result
// naming the button and its class (single click, double click or long press),
// while presses, repeated levels and button numbers at or above BUTTON_COUNT
// yield nothing. One event is accepted every clock cycle as long as the result
// side takes each result when it is offered; a result left waiting in the
// output register holds stage one, and with it the input, until it is taken.
// An event passes through one register stage, where the per-button start and
// last-release times are read from their memories, and its result is loaded
// into the output register when stage one moves on. A back-to-back event on
// the same button is served by forwarding the time just written. The user is
// to write configuration over the APB port only while no events are in flight;
// the block itself does not enforce this.
module button_click_classifier_top #(
  parameter int BUTTON_COUNT = bcc_pkg::BUTTON_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  bcc_in_if.sink                          in_ch,
  bcc_out_if.source                       out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [bcc_pkg::APB_ADDR_W-1:0]  cfg_paddr,
  input  logic [bcc_pkg::APB_DATA_W-1:0]  cfg_pwdata,
  output logic [bcc_pkg::APB_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);

  localparam int IDX_W  = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
  localparam int TIME_W = bcc_pkg::TIME_W;

  bcc_pkg::bcc_cfg_t cfg;

  // Configuration registers.
  bcc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_o       (cfg)
  );

  // Per-button state.
  logic [BUTTON_COUNT-1:0] pressed_r;
  logic [BUTTON_COUNT-1:0] ls_valid_r;
  logic [TIME_W-1:0]       pb_mem [BUTTON_COUNT];
  logic [TIME_W-1:0]       ls_mem [BUTTON_COUNT];
  logic [TIME_W-1:0]       pb_rd_r;
  logic [TIME_W-1:0]       ls_rd_r;

  // Stage-one registers.
  logic                         s1_valid_r;
  logic                         s1_hit_r;
  logic [IDX_W-1:0]             s1_idx_r;
  logic [bcc_pkg::BUTTON_W-1:0] s1_button_r;
  logic                         s1_level_r;
  logic [TIME_W-1:0]            s1_ts_r;
  logic                         byp_pb_r;
  logic                         byp_ls_r;
  logic [TIME_W-1:0]            byp_ts_r;

  // Output register.
  logic                         out_valid_r;
  logic [bcc_pkg::BUTTON_W-1:0] out_button_r;
  logic [bcc_pkg::KIND_W-1:0]   out_kind_r;

  logic              in_xfer;
  logic              in_range;
  logic [IDX_W-1:0]  rd_addr;
  logic              s1_adv;
  logic              pressed_cur;
  logic [TIME_W-1:0] pb_cur;
  logic [TIME_W-1:0] ls_cur;
  logic [TIME_W-1:0] held;
  logic [TIME_W-1:0] since_ls;
  logic              is_long;
  logic              is_dbl;
  logic              emit;
  logic              pb_we;
  logic              ls_we;
  bcc_pkg::kind_t    kind_nxt;

  // Handshake: stage one moves on whenever the output register is free or
  // being emptied; a new event enters whenever stage one moves or is empty.
  assign s1_adv       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  assign in_range = {1'b0, in_ch.button_index} < (bcc_pkg::BUTTON_W + 1)'(BUTTON_COUNT);
  assign rd_addr  = in_range ? in_ch.button_index[IDX_W-1:0] : '0;

  // Current state of the button in stage one, with forwarding of a time
  // written by the previous event on the same button.
  assign pressed_cur = pressed_r[s1_idx_r];
  assign pb_cur      = byp_pb_r ? byp_ts_r : pb_rd_r;
  assign ls_cur      = byp_ls_r ? byp_ts_r : (ls_valid_r[s1_idx_r] ? ls_rd_r : '0);

  // Classification: wrapped differences against the configured limits.
  assign held     = s1_ts_r - pb_cur;
  assign since_ls = s1_ts_r - ls_cur;
  assign is_long  = held >= {{(TIME_W-bcc_pkg::CFG_W){1'b0}}, cfg.long_press_time};
  assign is_dbl   = since_ls < {{(TIME_W-bcc_pkg::CFG_W){1'b0}}, cfg.double_click_window};
  assign emit     = s1_hit_r && !s1_level_r && pressed_cur;

  always_comb begin
    if (is_long) begin
      kind_nxt = bcc_pkg::KIND_LONG;
    end else if (is_dbl) begin
      kind_nxt = bcc_pkg::KIND_DOUBLE;
    end else begin
      kind_nxt = bcc_pkg::KIND_SINGLE;
    end
  end

  assign pb_we = s1_adv && s1_hit_r && s1_level_r && !pressed_cur;
  assign ls_we = s1_adv && emit && !is_long;

  // Stage-one register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_hit_r    <= in_range;
      s1_idx_r    <= rd_addr;
      s1_button_r <= in_ch.button_index;
      s1_level_r  <= in_ch.level_pressed;
      s1_ts_r     <= in_ch.timestamp_ms;
      byp_pb_r    <= pb_we && (s1_idx_r == rd_addr);
      byp_ls_r    <= ls_we && (s1_idx_r == rd_addr);
      byp_ts_r    <= s1_ts_r;
    end
  end

  // Press start time memory.
  always_ff @(posedge clk) begin
    if (pb_we) begin
      pb_mem[s1_idx_r] <= s1_ts_r;
    end
    if (in_xfer) begin
      pb_rd_r <= pb_mem[rd_addr];
    end
  end

  // Last short release time memory.
  always_ff @(posedge clk) begin
    if (ls_we) begin
      ls_mem[s1_idx_r] <= s1_ts_r;
    end
    if (in_xfer) begin
      ls_rd_r <= ls_mem[rd_addr];
    end
  end

  // Pressed flags and last-release valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r  <= '0;
      ls_valid_r <= '0;
    end else begin
      if (pb_we) begin
        pressed_r[s1_idx_r] <= 1'b1;
      end else if (s1_adv && emit) begin
        pressed_r[s1_idx_r] <= 1'b0;
      end
      if (ls_we) begin
        ls_valid_r[s1_idx_r] <= 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= emit;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      out_button_r <= s1_button_r;
      out_kind_r   <= kind_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.event_button = out_button_r;
  assign out_ch.event_kind   = out_kind_r;

`ifndef SYNTHESIS
  // A classified release leaves its button unpressed.
  a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && emit) |=> !pressed_r[$past(s1_idx_r)])
    else $error("button still pressed after a classified release");

  // A result only appears when stage one hands an event on.
  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_adv))
    else $error("result appeared without an event leaving stage one");

  // A long press does not touch the last short release record.
  a_long_keeps_ls: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && emit && is_long) |=> $stable(ls_valid_r))
    else $error("long press changed the last short release record");
`endif

endmodule

FILE: bench/button_click_classifier_top_tb.sv
// One expected classification: the button and its class.
typedef struct packed {
  logic [bcc_pkg::BUTTON_W-1:0] button;
  bcc_pkg::kind_t               kind;
} click_t;

// Tracks every button the way the block should, and holds the classifications
// still owed by the block in order of arrival.
class click_scoreboard;
  localparam int NB = bcc_pkg::BUTTON_COUNT_DEF;

  logic [bcc_pkg::CFG_W-1:0]  window_ms;
  logic [bcc_pkg::CFG_W-1:0]  long_ms;
  bit                         held_down [NB];
  logic [bcc_pkg::TIME_W-1:0] down_since [NB];
  logic [bcc_pkg::TIME_W-1:0] last_short [NB];
  click_t                     pending_q [$];
  int fail_count;
  int event_count;
  int ignored_count;
  int single_count;
  int double_count;
  int long_count;

  function new();
    window_ms     = bcc_pkg::DCW_RESET;
    long_ms       = bcc_pkg::LPT_RESET;
    fail_count    = 0;
    event_count   = 0;
    ignored_count = 0;
    single_count  = 0;
    double_count  = 0;
    long_count    = 0;
    for (int i = 0; i < NB; i++) begin
      held_down[i]  = 1'b0;
      down_since[i] = '0;
      last_short[i] = '0;
    end
  endfunction

  // Applies one accepted input transfer and queues the classification it owes.
  function void record_event(logic [bcc_pkg::BUTTON_W-1:0] b, logic lvl,
                             logic [bcc_pkg::TIME_W-1:0] ts);
    logic [bcc_pkg::TIME_W-1:0] hold;
    logic [bcc_pkg::TIME_W-1:0] since_short;
    click_t                     res;
    event_count++;
    if (b >= NB) begin
      ignored_count++;
      return;
    end
    // A press only matters on a button that is up.
    if (lvl) begin
      if (!held_down[b]) begin
        held_down[b]  = 1'b1;
        down_since[b] = ts;
      end
      return;
    end
    // A release of a button that is up is dropped.
    if (!held_down[b]) return;
    held_down[b] = 1'b0;
    hold         = ts - down_since[b];
    res.button   = b;
    if (hold >= {16'h0, long_ms}) begin
      res.kind = bcc_pkg::KIND_LONG;
      long_count++;
    end else begin
      since_short = ts - last_short[b];
      if (since_short < {16'h0, window_ms}) begin
        res.kind = bcc_pkg::KIND_DOUBLE;
        double_count++;
      end else begin
        res.kind = bcc_pkg::KIND_SINGLE;
        single_count++;
      end
      last_short[b] = ts;
    end
    pending_q.push_back(res);
  endfunction

  // Compares one result transfer with the oldest classification owed.
  function void check_event(logic [bcc_pkg::BUTTON_W-1:0] b,
                            logic [bcc_pkg::KIND_W-1:0] k);
    click_t want;
    if (pending_q.size() == 0) begin
      $error("unexpected result: event_button %0d, event_kind %0d", b, k);
      fail_count++;
      return;
    end
    want = pending_q.pop_front();
    if (b !== want.button) begin
      $error("event_button: expected %0d, actual %0d", want.button, b);
      fail_count++;
    end
    if (k !== want.kind) begin
      $error("event_kind: expected %0d, actual %0d", want.kind, k);
      fail_count++;
    end
  endfunction
endclass

module button_click_classifier_top_tb;

  localparam int NB          = bcc_pkg::BUTTON_COUNT_DEF;
  localparam int CYCLE_CAP   = 400000;
  localparam int SETTLE      = 6;
  localparam int PHASE_ITEMS = 75;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_psel;
  logic                           cfg_penable;
  logic                           cfg_pwrite;
  logic [bcc_pkg::APB_ADDR_W-1:0] cfg_paddr;
  logic [bcc_pkg::APB_DATA_W-1:0] cfg_pwdata;
  logic [bcc_pkg::APB_DATA_W-1:0] cfg_prdata;
  logic                           cfg_pready;

  bcc_in_if  in_if ();
  bcc_out_if out_if ();

  click_scoreboard            sb;
  bit                         idle_on;
  int                         cycle_count;
  int                         setting_count;
  logic [bcc_pkg::TIME_W-1:0] cursor_ms;

  button_click_classifier_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if.sink),
    .out_ch      (out_if.source),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog on the whole run.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_CAP) begin
      $display("[button_click_classifier_top] ERROR");
      $finish;
    end
  end

  // Result side: check each transfer and, while idling is on, stall at random.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready)
        sb.check_event(out_if.event_button, out_if.event_kind);
      out_if.ready <= idle_on ? ($urandom_range(0, 99) >= 31) : 1'b1;
    end
  end

  // Offers one event and waits for its transfer; valid stays high afterwards.
  task automatic send_event(logic [bcc_pkg::BUTTON_W-1:0] b, logic lvl,
                            logic [bcc_pkg::TIME_W-1:0] ts);
    while (idle_on && $urandom_range(0, 99) < 31) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.button_index  <= b;
    in_if.level_pressed <= lvl;
    in_if.timestamp_ms  <= ts;
    do @(posedge clk); while (!in_if.ready);
    sb.record_event(b, lvl, ts);
  endtask

  // Holds the sender off until every owed result has come, then lets the
  // pipeline empty of events that owe nothing.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes one register, then reads it back.
  task automatic write_register(bcc_pkg::reg_idx_t idx, logic [bcc_pkg::CFG_W-1:0] value);
    logic [bcc_pkg::APB_DATA_W-1:0] readback;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= bcc_pkg::APB_ADDR_W'({idx, 2'b00});
    cfg_pwdata  <= {16'($urandom), value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    // Straight into the setup of the read.
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    readback = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (readback[bcc_pkg::CFG_W-1:0] !== value) begin
      $error("register %0d readback: expected %0d, actual %0d", idx, value,
             readback[bcc_pkg::CFG_W-1:0]);
      sb.fail_count++;
    end
    if (idx == bcc_pkg::REG_DCW) sb.window_ms = value;
    else sb.long_ms = value;
  endtask

  task automatic apply_setting(logic [bcc_pkg::CFG_W-1:0] window,
                               logic [bcc_pkg::CFG_W-1:0] hold_min);
    drain_results();
    write_register(bcc_pkg::REG_DCW, window);
    write_register(bcc_pkg::REG_LPT, hold_min);
    setting_count++;
  endtask

  // Spacing between a release and the next press, scaled to the settings so
  // that doubles and singles both turn up.
  function automatic logic [bcc_pkg::TIME_W-1:0] press_gap();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, sb.window_ms / 2 + 1);
      4, 5, 6, 7: return $urandom_range(0, 2 * sb.window_ms + 2);
      8:          return $urandom_range(0, 3 * sb.long_ms + 3);
      default:    return $urandom;
    endcase
  endfunction

  // Release time for a held button, clustered round both thresholds.
  function automatic logic [bcc_pkg::TIME_W-1:0] release_time(
      logic [bcc_pkg::BUTTON_W-1:0] b);
    logic [bcc_pkg::TIME_W-1:0] start;
    start = sb.down_since[b];
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return start + $urandom_range(0, sb.long_ms);
      4:          return start + sb.long_ms - 1;
      5:          return start + sb.long_ms;
      6:          return start + $urandom_range(0, 3 * sb.long_ms + 3);
      7:          return sb.last_short[b] + sb.window_ms - $urandom_range(0, 1);
      8:          return start + $urandom_range(0, 200);
      default:    return $urandom;
    endcase
  endfunction

  // Mostly press and release pairs on live buttons, with some out-of-range
  // buttons, repeated levels and fully random events mixed in.
  task automatic random_events(int target);
    int                           counted;
    int                           pick;
    logic [bcc_pkg::BUTTON_W-1:0] b;
    logic                         lvl;
    logic [bcc_pkg::TIME_W-1:0]   ts;
    counted = 0;
    while (counted < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        b   = bcc_pkg::BUTTON_W'($urandom);
        lvl = 1'($urandom);
        ts  = $urandom;
      end else begin
        if (pick < 12) b = bcc_pkg::BUTTON_W'($urandom_range(NB, 63));
        else b = bcc_pkg::BUTTON_W'($urandom_range(0, NB - 1));
        if (b >= NB || !sb.held_down[b]) begin
          lvl       = ($urandom_range(0, 9) != 0);
          cursor_ms = cursor_ms + press_gap();
          ts        = cursor_ms;
        end else begin
          lvl = ($urandom_range(0, 6) == 0);
          if (lvl) begin
            ts = cursor_ms;
          end else begin
            ts        = release_time(b);
            cursor_ms = ts;
          end
        end
      end
      send_event(b, lvl, ts);
      counted++;
    end
  endtask

  // Hand-picked events under the reset settings.
  task automatic directed_events();
    // Buttons at or above the count are ignored.
    send_event(6'd4, 1'b1, 32'd0);
    send_event(6'd63, 1'b1, 32'd5);
    send_event(6'd63, 1'b0, 32'd50);
    // Release of a button that was never pressed.
    send_event(6'd0, 1'b0, 32'd10);
    // First short release after reset lies inside the window of time zero.
    send_event(6'd0, 1'b1, 32'd0);
    send_event(6'd0, 1'b0, 32'd100);
    // A chained quick click is again a double.
    send_event(6'd0, 1'b1, 32'd200);
    send_event(6'd0, 1'b0, 32'd250);
    // A repeated press, then a long hold that leaves the last release alone.
    send_event(6'd0, 1'b1, 32'd260);
    send_event(6'd0, 1'b1, 32'd270);
    send_event(6'd0, 1'b0, 32'd1000);
    send_event(6'd0, 1'b1, 32'd1010);
    send_event(6'd0, 1'b0, 32'd1020);
    // A plain single click far from any earlier release.
    send_event(6'd1, 1'b1, 32'd5000);
    send_event(6'd1, 1'b0, 32'd5100);
    // Holds at the long press threshold and one below it.
    send_event(6'd1, 1'b1, 32'd6000);
    send_event(6'd1, 1'b0, 32'd6599);
    send_event(6'd1, 1'b1, 32'd7000);
    send_event(6'd1, 1'b0, 32'd7600);
    // A hold across the wrap of the millisecond counter.
    send_event(6'd2, 1'b1, 32'hFFFF_FF00);
    send_event(6'd2, 1'b0, 32'h0000_0100);
    // Zero hold at the top of the time range.
    send_event(6'd3, 1'b1, 32'hFFFF_FFFF);
    send_event(6'd3, 1'b0, 32'hFFFF_FFFF);
    send_event(6'd3, 1'b1, 32'h5555_AAAA);
    send_event(6'd3, 1'b0, 32'h5555_AB00);
  endtask

  // Reset, directed events, then random events under a series of settings.
  initial begin
    sb            = new();
    idle_on       = 1'b1;
    setting_count = 1;
    cursor_ms     = '0;
    rst_n               <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.button_index  <= '0;
    in_if.level_pressed <= 1'b0;
    in_if.timestamp_ms  <= '0;
    cfg_psel            <= 1'b0;
    cfg_penable         <= 1'b0;
    cfg_pwrite          <= 1'b0;
    cfg_paddr           <= '0;
    cfg_pwdata          <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    directed_events();

    // A long stretch without any idling on either side.
    idle_on = 1'b0;
    random_events(PHASE_ITEMS);
    idle_on = 1'b1;

    // Pause for every owed result, then go on with the reset settings.
    drain_results();
    random_events(PHASE_ITEMS);

    apply_setting(16'd0, 16'd0);
    random_events(PHASE_ITEMS / 2);
    apply_setting(16'hFFFF, 16'hFFFF);
    random_events(PHASE_ITEMS);
    apply_setting(16'd0, 16'hFFFF);
    random_events(PHASE_ITEMS);
    apply_setting(16'hFFFF, 16'd0);
    random_events(PHASE_ITEMS / 2);
    apply_setting(bcc_pkg::CFG_W'($urandom_range(1, 2000)),
                  bcc_pkg::CFG_W'($urandom_range(1, 3000)));
    random_events(PHASE_ITEMS);
    apply_setting(16'd40, 16'd120);
    random_events(PHASE_ITEMS);

    drain_results();
    $display("Covered %0d events (%0d ignored) under %0d register settings.",
             sb.event_count, sb.ignored_count, setting_count);
    $display("Classified %0d single clicks, %0d double clicks and %0d long presses.",
             sb.single_count, sb.double_count, sb.long_count);
    if (sb.fail_count == 0 && sb.pending_q.size() == 0) begin
      $display("[button_click_classifier_top] OK");
    end else begin
      $display("[button_click_classifier_top] ERROR");
    end
    $finish;
  end
endmodule
